// ----- hw/rtl/compact_integer_codec_defines.svh -----
// ----------------------------------------------------------------------------
// Compact integer codec: assertion macros
// Shared concurrent assertion helpers, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef COMPACT_INTEGER_CODEC_DEFINES_SVH
`define COMPACT_INTEGER_CODEC_DEFINES_SVH

`ifndef ASSERT_OFF
// Property must hold at every rising edge outside reset.
`define CIC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("compact_integer_codec assertion failed");
// Condition must never be true outside reset.
`define CIC_ASSERT_NEVER(lbl, cond) \
  `CIC_ASSERT(lbl, !(cond))
`else
`define CIC_ASSERT(lbl, prop)
`define CIC_ASSERT_NEVER(lbl, cond)
`endif

`endif

// ----- hw/rtl/cic_pkg.sv -----
// ----------------------------------------------------------------------------
// Compact integer codec package
// Types and constants shared by the front end, queue and back end.
// ----------------------------------------------------------------------------
package cic_pkg;

  // Command codes.
  localparam logic CMD_ENCODE = 1'b0;
  localparam logic CMD_DECODE = 1'b1;

  // Result kinds.
  localparam logic KIND_BYTE  = 1'b0;
  localparam logic KIND_VALUE = 1'b1;

  // Encode limits and prefixes.
  localparam logic [31:0] U_LIM1 = 32'h0000_0080;
  localparam logic [31:0] U_LIM2 = 32'h0000_8000;
  localparam logic [31:0] U_LIM4 = 32'h2000_0000;
  localparam logic [31:0] S_LIM1 = 32'h0000_0040;
  localparam logic [31:0] S_LIM2 = 32'h0000_2000;
  localparam logic [31:0] S_LIM4 = 32'h1000_0000;

  localparam logic [7:0]  P1_POS = 8'h00;
  localparam logic [7:0]  P1_NEG = 8'h40;
  localparam logic [15:0] P2_POS = 16'h8000;
  localparam logic [15:0] P2_NEG = 16'ha000;
  localparam logic [31:0] P4_POS = 32'hc000_0000;
  localparam logic [31:0] P4_NEG = 32'hd000_0000;
  localparam logic [7:0]  P5_POS = 8'he0;
  localparam logic [7:0]  P5_NEG = 8'hf0;

  localparam int unsigned JOB_BYTES = 5;
  localparam int unsigned CNT_W     = 3;

  // One unit of work for the back end. Encoded bytes sit left aligned in
  // data, first byte in the top eight bits; a decoded value sits in the low
  // 32 bits.
  typedef struct packed {
    logic                     kind;
    logic [CNT_W-1:0]         cnt;
    logic [JOB_BYTES*8-1:0]   data;
  } job_t;

endpackage

// ----- hw/rtl/cic_front.sv -----
// ----------------------------------------------------------------------------
// Compact integer codec front end
// Classifies each transaction, formats encode bytes, tracks decode state.
// ----------------------------------------------------------------------------
module cic_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  logic          cmd_i,
  input  logic          signed_mode_i,
  input  logic [31:0]   value_in_i,
  input  logic [7:0]    byte_in_i,
  output logic          push_o,
  output cic_pkg::job_t job_o
);

  logic [2:0]  bytes_left_q, bytes_left_d;
  logic [31:0] acc_q, acc_d;
  logic        negate_q, negate_d;

  // Encode path.
  logic        enc_neg;
  logic [31:0] mag;
  logic [31:0] lim1, lim2, lim4;
  logic [39:0] enc_data;
  logic [2:0]  enc_cnt;

  always_comb begin
    enc_neg = signed_mode_i & value_in_i[31];
    mag     = enc_neg ? (32'd0 - value_in_i) : value_in_i;
    lim1    = signed_mode_i ? cic_pkg::S_LIM1 : cic_pkg::U_LIM1;
    lim2    = signed_mode_i ? cic_pkg::S_LIM2 : cic_pkg::U_LIM2;
    lim4    = signed_mode_i ? cic_pkg::S_LIM4 : cic_pkg::U_LIM4;
    if (mag < lim1) begin
      enc_cnt  = 3'd1;
      enc_data = {mag[7:0] | (enc_neg ? cic_pkg::P1_NEG : cic_pkg::P1_POS), 32'd0};
    end else if (mag < lim2) begin
      enc_cnt  = 3'd2;
      enc_data = {mag[15:0] | (enc_neg ? cic_pkg::P2_NEG : cic_pkg::P2_POS), 24'd0};
    end else if (mag < lim4) begin
      enc_cnt  = 3'd4;
      enc_data = {mag | (enc_neg ? cic_pkg::P4_NEG : cic_pkg::P4_POS), 8'd0};
    end else begin
      enc_cnt  = 3'd5;
      enc_data = {(enc_neg ? cic_pkg::P5_NEG : cic_pkg::P5_POS), mag};
    end
  end

  // Decode path: classify the first byte.
  logic [2:0]  len;
  logic [7:0]  first;
  logic        first_neg;
  logic [7:0]  b;

  always_comb begin
    b         = byte_in_i;
    len       = 3'd1;
    first     = b;
    first_neg = 1'b0;
    if (!signed_mode_i) begin
      case (b[7:5])
        3'b111: begin
          len   = 3'd5;
          first = 8'h00;
        end
        3'b110: begin
          len   = 3'd4;
          first = b & 8'h3f;
        end
        3'b101, 3'b100: begin
          len   = 3'd2;
          first = b & 8'h7f;
        end
        default: begin
          len   = 3'd1;
          first = b;
        end
      endcase
    end else begin
      case (b[7:4])
        4'b1111: begin
          len       = 3'd5;
          first     = 8'h00;
          first_neg = 1'b1;
        end
        4'b1110: begin
          len   = 3'd5;
          first = 8'h00;
        end
        4'b1101, 4'b1100: begin
          len       = 3'd4;
          first     = b & 8'h2f;
          first_neg = b[4];
        end
        4'b1011, 4'b1010: begin
          len       = 3'd2;
          first     = b & 8'h5f;
          first_neg = 1'b1;
        end
        4'b1001, 4'b1000: begin
          len   = 3'd2;
          first = b & 8'h7f;
        end
        4'b0111, 4'b0110, 4'b0101, 4'b0100: begin
          len       = 3'd1;
          first     = b & 8'h3f;
          first_neg = 1'b1;
        end
        default: begin
          len   = 3'd1;
          first = b;
        end
      endcase
    end
  end

  logic        is_first;
  logic        dec_done;
  logic [31:0] dec_raw;
  logic        dec_negate;
  logic [31:0] dec_value;

  always_comb begin
    is_first     = (bytes_left_q == 3'd0);
    bytes_left_d = bytes_left_q;
    acc_d        = acc_q;
    negate_d     = negate_q;
    if (is_first) begin
      dec_raw    = {24'd0, first};
      dec_negate = first_neg;
      dec_done   = (len == 3'd1);
    end else begin
      dec_raw    = {acc_q[23:0], b};
      dec_negate = negate_q;
      dec_done   = (bytes_left_q == 3'd1);
    end
    dec_value = dec_negate ? (32'd0 - dec_raw) : dec_raw;
    if (accept_i && (cmd_i == cic_pkg::CMD_DECODE)) begin
      acc_d    = dec_raw;
      negate_d = dec_negate;
      if (is_first) begin
        bytes_left_d = len - 3'd1;
      end else begin
        bytes_left_d = bytes_left_q - 3'd1;
      end
    end
  end

  always_comb begin
    job_o = '0;
    if (cmd_i == cic_pkg::CMD_ENCODE) begin
      job_o.kind = cic_pkg::KIND_BYTE;
      job_o.cnt  = enc_cnt;
      job_o.data = enc_data;
      push_o     = accept_i;
    end else begin
      job_o.kind = cic_pkg::KIND_VALUE;
      job_o.cnt  = 3'd1;
      job_o.data = {8'd0, dec_value};
      push_o     = accept_i & dec_done;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_left_q <= 3'd0;
      acc_q        <= 32'd0;
      negate_q     <= 1'b0;
    end else begin
      bytes_left_q <= bytes_left_d;
      acc_q        <= acc_d;
      negate_q     <= negate_d;
    end
  end

endmodule

// ----- hw/rtl/cic_queue.sv -----
// ----------------------------------------------------------------------------
// Compact integer codec job queue
// Short register FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
`include "compact_integer_codec_defines.svh"

module cic_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  cic_pkg::job_t job_i,
  input  logic          pop_i,
  output cic_pkg::job_t job_o,
  output logic          full_o,
  output logic          empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cic_pkg::job_t    mem_q [DEPTH];
  logic [PTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign job_o   = mem_q[rptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (do_push) begin
      wptr_d = (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= job_i;
    end
  end

  `CIC_ASSERT_NEVER(a_queue_overflow, push_i && full_o)
  `CIC_ASSERT_NEVER(a_queue_count_range, count_q > CNT_W'(DEPTH))
  `CIC_ASSERT(a_queue_push_lands, (do_push && !do_pop) |=> !empty_o)

endmodule

// ----- hw/rtl/cic_back.sv -----
// ----------------------------------------------------------------------------
// Compact integer codec back end
// Pulls jobs from the queue and presents them one result at a time.
// ----------------------------------------------------------------------------
`include "compact_integer_codec_defines.svh"

module cic_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cic_pkg::job_t job_i,
  input  logic          empty_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic          out_kind_o,
  output logic [7:0]    out_byte_o,
  output logic          last_o,
  output logic [31:0]   value_out_o
);

  logic          cur_valid_q, cur_valid_d;
  cic_pkg::job_t cur_q, cur_d;
  logic          take;
  logic          is_value;

  assign is_value    = (cur_q.kind == cic_pkg::KIND_VALUE);
  assign out_valid_o = cur_valid_q;
  assign out_kind_o  = cur_q.kind;
  assign out_byte_o  = is_value ? 8'd0 : cur_q.data[39:32];
  assign last_o      = is_value | (cur_q.cnt == 3'd1);
  assign value_out_o = is_value ? cur_q.data[31:0] : 32'd0;
  assign take        = cur_valid_q & ~out_stall_i;

  // The next job loads when none is held or the last result is handed over.
  assign pop_o = ~empty_i & (~cur_valid_q | (take & last_o));

  always_comb begin
    cur_valid_d = cur_valid_q;
    cur_d       = cur_q;
    if (!cur_valid_q || (take && last_o)) begin
      cur_valid_d = ~empty_i;
      cur_d       = job_i;
    end else if (take) begin
      cur_d.cnt  = cur_q.cnt - 3'd1;
      cur_d.data = {cur_q.data[31:0], 8'd0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
    end else begin
      cur_valid_q <= cur_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

  `CIC_ASSERT_NEVER(a_back_cnt_zero, cur_valid_q && (cur_q.cnt == 3'd0))
  `CIC_ASSERT_NEVER(a_back_cnt_range, cur_valid_q && (cur_q.cnt > 3'd5))
  `CIC_ASSERT(a_back_continues, (take && !last_o) |=> (cur_valid_q && !is_value))

endmodule

// ----- hw/rtl/compact_integer_codec.sv -----
// ----------------------------------------------------------------------------
// Compact integer codec
// Encodes 32-bit values into 1, 2, 4 or 5 prefix-length bytes and decodes
// such byte streams back into values, in unsigned or signed format.
//
// Input channel: in_valid_i / in_stall_o. A transaction is either an encode
// of value_in_i (cmd_i low) or one stream byte byte_in_i to decode.
// Output channel: out_valid_o / out_stall_i. An encode gives one result per
// byte, most significant first, last_o on the final byte. A decode gives one
// result, with the value, after the final byte of a coded value.
// A result passes through the job queue, then the back-end output register.
// Throughput: one input transaction per cycle while in_stall_o is low; the
// output side moves one result per cycle while out_stall_i is low, and an
// encode takes one result per byte. The job queue between the front and back
// ends absorbs the difference, and in_stall_o rises only while it is full.
// Reset clears the decode state (awaiting a first byte), the queue and the
// output register. While out_stall_i is high the current result holds.
// ----------------------------------------------------------------------------
module compact_integer_codec #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        cmd_i,
  input  logic        signed_mode_i,
  input  logic [31:0] value_in_i,
  input  logic [7:0]  byte_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        out_kind_o,
  output logic [7:0]  out_byte_o,
  output logic        last_o,
  output logic [31:0] value_out_o
);

  logic          accept;
  logic          push;
  logic          pop;
  logic          full;
  logic          empty;
  cic_pkg::job_t front_job;
  cic_pkg::job_t head_job;

  assign in_stall_o = full;
  assign accept     = in_valid_i & ~full;

  cic_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .cmd_i        (cmd_i),
    .signed_mode_i(signed_mode_i),
    .value_in_i   (value_in_i),
    .byte_in_i    (byte_in_i),
    .push_o       (push),
    .job_o        (front_job)
  );

  cic_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (front_job),
    .pop_i  (pop),
    .job_o  (head_job),
    .full_o (full),
    .empty_o(empty)
  );

  cic_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_i      (head_job),
    .empty_i    (empty),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_kind_o (out_kind_o),
    .out_byte_o (out_byte_o),
    .last_o     (last_o),
    .value_out_o(value_out_o)
  );

endmodule

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// Compact integer codec testbench
// Drives encode and decode transactions with random gaps and output stalls.
// A scoreboard predicts every encoded byte and decoded value and checks the
// results in order.
// ----------------------------------------------------------------------------
module tb_top;

  class codec_scoreboard;
    typedef struct packed {
      logic        kind;
      logic [7:0]  code_byte;
      logic        last;
      logic [31:0] value;
    } codec_result_t;

    codec_result_t pending_results[$];
    logic [2:0]    bytes_left;
    logic [31:0]   acc;
    logic          negate;
    int unsigned   errors;
    int unsigned   bytes_checked;
    int unsigned   values_checked;

    function new();
      bytes_left     = '0;
      acc            = '0;
      negate         = 1'b0;
      errors         = 0;
      bytes_checked  = 0;
      values_checked = 0;
    endfunction

    // Codes a value; the bytes come back left aligned, first byte on top.
    static function void pack_value(input logic [31:0] x, input logic sgn,
                                    output logic [39:0] code, output int unsigned n);
      logic [31:0] mag, lim1, lim2, lim4, p4, w;
      logic [15:0] p2;
      logic [7:0]  p1, p5;
      mag  = x;
      lim1 = cic_pkg::U_LIM1;
      lim2 = cic_pkg::U_LIM2;
      lim4 = cic_pkg::U_LIM4;
      p1   = cic_pkg::P1_POS;
      p2   = cic_pkg::P2_POS;
      p4   = cic_pkg::P4_POS;
      p5   = cic_pkg::P5_POS;
      if (sgn) begin
        lim1 = cic_pkg::S_LIM1;
        lim2 = cic_pkg::S_LIM2;
        lim4 = cic_pkg::S_LIM4;
        if (x[31]) begin
          mag = 32'd0 - x;
          p1  = cic_pkg::P1_NEG;
          p2  = cic_pkg::P2_NEG;
          p4  = cic_pkg::P4_NEG;
          p5  = cic_pkg::P5_NEG;
        end
      end
      if (mag < lim1) begin
        code = {mag[7:0] | p1, 32'h0};
        n    = 1;
      end else if (mag < lim2) begin
        w    = mag | {16'h0, p2};
        code = {w[15:0], 24'h0};
        n    = 2;
      end else if (mag < lim4) begin
        w    = mag | p4;
        code = {w, 8'h0};
        n    = 4;
      end else begin
        code = {p5, mag};
        n    = 5;
      end
    endfunction

    function void push_value();
      pending_results.push_back({cic_pkg::KIND_VALUE, 8'h00, 1'b1,
                                 negate ? 32'd0 - acc : acc});
    endfunction

    // Works out the results of one accepted input transaction.
    function void note_input(input logic cmd, input logic sm, input logic [31:0] value_in,
                             input logic [7:0] byte_in);
      logic [39:0] code;
      int unsigned n;
      logic [2:0]  len;
      logic [31:0] first;
      if (cmd == cic_pkg::CMD_ENCODE) begin
        pack_value(value_in, sm, code, n);
        for (int unsigned i = 0; i < n; i++)
          pending_results.push_back({cic_pkg::KIND_BYTE, code[39-8*i -: 8], i == n - 1,
                                     32'h0});
      end else if (bytes_left == 0) begin
        negate = 1'b0;
        first  = {24'h0, byte_in};
        if (!sm) begin
          casez (byte_in[7:5])
            3'b111: begin len = 3'd5; first = '0; end
            3'b110: begin len = 3'd4; first = {24'h0, byte_in & 8'h3f}; end
            3'b10?: begin len = 3'd2; first = {24'h0, byte_in & 8'h7f}; end
            default: len = 3'd1;
          endcase
        end else begin
          casez (byte_in[7:4])
            4'b1111: begin len = 3'd5; first = '0; negate = 1'b1; end
            4'b1110: begin len = 3'd5; first = '0; end
            4'b110?: begin
              len    = 3'd4;
              first  = {24'h0, byte_in & 8'h2f};
              negate = byte_in[4];
            end
            4'b101?: begin len = 3'd2; first = {24'h0, byte_in & 8'h5f}; negate = 1'b1; end
            4'b100?: begin len = 3'd2; first = {24'h0, byte_in & 8'h7f}; end
            4'b01??: begin len = 3'd1; first = {24'h0, byte_in & 8'h3f}; negate = 1'b1; end
            default: len = 3'd1;
          endcase
        end
        acc        = first;
        bytes_left = len - 3'd1;
        if (bytes_left == 0) push_value();
      end else begin
        acc        = {acc[23:0], byte_in};
        bytes_left = bytes_left - 3'd1;
        if (bytes_left == 0) push_value();
      end
    endfunction

    task report(input string msg);
      errors++;
      $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    task compare_field(input string name, input logic [31:0] got, input logic [31:0] want);
      if (got !== want)
        report($sformatf("%s is %08h, predicted %08h", name, got, want));
    endtask

    task check_result(input logic kind, input logic [7:0] code_byte, input logic last,
                      input logic [31:0] value);
      codec_result_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("unpredicted result: kind %0d byte %02h last %0d value %08h",
                         kind, code_byte, last, value));
        return;
      end
      want = pending_results.pop_front();
      compare_field("out_kind", {31'h0, kind}, {31'h0, want.kind});
      compare_field("out_byte", {24'h0, code_byte}, {24'h0, want.code_byte});
      compare_field("last", {31'h0, last}, {31'h0, want.last});
      compare_field("value_out", value, want.value);
      if (want.kind == cic_pkg::KIND_BYTE) bytes_checked++;
      else values_checked++;
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        cmd_i;
  logic        signed_mode_i;
  logic [31:0] value_in_i;
  logic [7:0]  byte_in_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic        out_kind_o;
  logic [7:0]  out_byte_o;
  logic        last_o;
  logic [31:0] value_out_o;

  codec_scoreboard sb = new();
  int unsigned     items;
  int unsigned     encodes;
  bit              steady;

  compact_integer_codec dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .cmd_i         (cmd_i),
    .signed_mode_i (signed_mode_i),
    .value_in_i    (value_in_i),
    .byte_in_i     (byte_in_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_kind_o    (out_kind_o),
    .out_byte_o    (out_byte_o),
    .last_o        (last_o),
    .value_out_o   (value_out_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #2400000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic bit idle_now();
    return !steady && ($urandom_range(0, 99) < 7);
  endfunction

  // Spreads values over every code length, small magnitudes and large ones.
  function automatic logic [31:0] random_value();
    logic [31:0] x;
    x = $urandom >> $urandom_range(0, 31);
    if ($urandom_range(0, 1)) x = ~x;
    return x;
  endfunction

  always @(posedge clk_i) begin
    out_stall_i <= idle_now();
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result(out_kind_o, out_byte_o, last_o, value_out_o);
  end

  task automatic send_item(input logic cmd, input logic sm, input logic [31:0] value,
                           input logic [7:0] data);
    while (idle_now()) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    cmd_i         <= cmd;
    signed_mode_i <= sm;
    value_in_i    <= value;
    byte_in_i     <= data;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_input(cmd, sm, value, data);
    items++;
    if (cmd == cic_pkg::CMD_ENCODE) encodes++;
  endtask

  task automatic send_encode(input logic [31:0] x, input logic sgn);
    send_item(cic_pkg::CMD_ENCODE, sgn, x, 8'($urandom));
  endtask

  // Feeds the coded form of x as decode bytes. The decoder is first brought
  // back to a value boundary with stray bytes. Only the first keep bytes are
  // sent, and encodes may be slipped in before any byte.
  task automatic send_stream(input logic [31:0] x, input logic sgn, input int unsigned keep,
                             input int unsigned mix_pct);
    logic [39:0] code;
    int unsigned n;
    while (sb.bytes_left != 0)
      send_item(cic_pkg::CMD_DECODE, 1'($urandom), $urandom, 8'($urandom));
    codec_scoreboard::pack_value(x, sgn, code, n);
    if (keep < n) n = keep;
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < mix_pct)
        send_encode(random_value(), 1'($urandom));
      send_item(cic_pkg::CMD_DECODE, (i == 0) ? sgn : 1'($urandom), $urandom,
                code[39-8*i -: 8]);
    end
  endtask

  initial begin
    logic [31:0] u_bounds[7];
    logic [31:0] s_bounds[7];
    int unsigned pick;
    int unsigned wait_cycles;
    u_bounds      = '{32'h0, 32'h7f, 32'h80, 32'h8000, 32'h1fff_ffff,
                      32'h2000_0000, 32'hffff_ffff};
    s_bounds      = '{32'h3f, 32'h40, 32'h1000_0000, 32'hffff_ffc1,
                      32'hffff_ffc0, 32'hffff_e000, 32'h8000_0000};
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    cmd_i         = cic_pkg::CMD_ENCODE;
    signed_mode_i = 1'b0;
    value_in_i    = '0;
    byte_in_i     = '0;
    out_stall_i   = 1'b0;
    steady        = 1'b0;
    items         = 0;
    encodes       = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Length boundaries of both formats, including the most negative value.
    foreach (u_bounds[i]) send_encode(u_bounds[i], 1'b0);
    foreach (s_bounds[i]) send_encode(s_bounds[i], 1'b1);
    // One-byte decodes: unsigned, signed negative and signed positive.
    send_item(cic_pkg::CMD_DECODE, 1'b0, 32'h0, 8'h7f);
    send_item(cic_pkg::CMD_DECODE, 1'b1, 32'h0, 8'h7f);
    send_item(cic_pkg::CMD_DECODE, 1'b1, 32'h0, 8'h3f);
    // An encode in the middle of a decode; the mode on the second byte is ignored.
    send_item(cic_pkg::CMD_DECODE, 1'b0, 32'h0, 8'ha0);
    send_item(cic_pkg::CMD_ENCODE, 1'b1, 32'hffff_ffff, 8'h0);
    send_item(cic_pkg::CMD_DECODE, 1'b1, 32'h0, 8'h01);
    send_stream(32'hf000_0001, 1'b1, 5, 0);

    while (items < 330) begin
      steady = (items >= 120 && items < 200);
      pick   = $urandom_range(0, 99);
      if (pick < 45)
        send_stream(random_value(), 1'($urandom), 5, 0);
      else if (pick < 55)
        send_stream(random_value(), 1'($urandom), 5, 30);
      else if (pick < 85)
        send_encode(random_value(), 1'($urandom));
      else if (pick < 93)
        send_stream(random_value(), 1'($urandom), $urandom_range(1, 4), 20);
      else
        send_item(cic_pkg::CMD_DECODE, 1'($urandom), $urandom, 8'($urandom));
    end
    steady     = 1'b0;
    in_valid_i <= 1'b0;

    wait_cycles = 0;
    while (sb.pending_results.size() != 0 && wait_cycles < 5000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (8) @(posedge clk_i);
    if (sb.pending_results.size() != 0)
      sb.report($sformatf("%0d predicted results never arrived", sb.pending_results.size()));

    $display("Sent %0d transactions (%0d encodes, %0d decode bytes).",
             items, encodes, items - encodes);
    $display("Checked %0d encoded bytes and %0d decoded values.",
             sb.bytes_checked, sb.values_checked);
    if (sb.errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end
endmodule

// ----- compact_integer_codec.f -----
+incdir+hw/rtl
hw/rtl/cic_pkg.sv
hw/rtl/cic_front.sv
hw/rtl/cic_queue.sv
hw/rtl/cic_back.sv
hw/rtl/compact_integer_codec.sv
tb/sv/tb_top.sv
